// ----- hdl/four_neighbour_wall_check_core_defines.svh -----
// ----------------------------------------------------------------------------
// four_neighbour_wall_check_core_defines
// assertion macros shared by the wall check core modules
// ----------------------------------------------------------------------------
`ifndef FOUR_NEIGHBOUR_WALL_CHECK_CORE_DEFINES_SVH
`define FOUR_NEIGHBOUR_WALL_CHECK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FWCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fwcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fwcc_pkg
// shared types and constants of the four neighbour wall check core
// ----------------------------------------------------------------------------
`default_nettype none

package fwcc_pkg;

    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 11;
    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 10;

    // register map
    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_WALL_CHAR = 2'd2;

    localparam logic [CFG_W-1:0]  GRID_ROWS_RESET = 11'd1;
    localparam logic [CFG_W-1:0]  GRID_COLS_RESET = 11'd1;
    localparam logic [CHAR_W-1:0] WALL_CHAR_RESET = 8'd35;

    // front to back queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // results caused by one transaction
    // a: cell above, b: cell to the left (last row), c: bottom-right cell
    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 has_a;
        logic                 has_b;
        logic                 has_c;
        logic                 pass_a;
        logic                 pass_b;
        logic                 pass_c;
    } bundle_t;

endpackage

`default_nettype wire

// ----- hdl/fwcc_ram.sv -----
// ----------------------------------------------------------------------------
// fwcc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fwcc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fwcc_front.sv -----
// ----------------------------------------------------------------------------
// fwcc_front
// raster position tracking, column history buffer and per-transaction
// neighbour classification
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_neighbour_wall_check_core_defines.svh"

module fwcc_front
    import fwcc_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              restart,
    input  wire logic [ROW_W-1:0]  last_row,
    input  wire logic [COL_W-1:0]  last_col,
    input  wire logic [CHAR_W-1:0] wall_char,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAR_W-1:0] cell_char,
    input  wire logic              fifo_full,
    output logic                   push,
    output bundle_t                push_data
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    // history bits per column: [1] row above, [0] two rows above
    logic [1:0]       slot0_reg, slot0_next;
    logic             ob_prev_reg, cur1_reg, cur2_reg;
    logic             byp_valid_reg, byp_valid_next;
    logic [1:0]       byp_data_reg;

    logic             accept;
    logic             w;
    logic [1:0]       wdata;
    logic [1:0]       ram_rdata;
    logic [1:0]       slot1;
    logic [COL_W-1:0] col_plus1;
    logic [COL_W-1:0] rd_addr;
    logic             r_ge1, r_ge2, c_ge1, c_ge2, c_last, r_last;
    logic             pass_a, pass_b, pass_c;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign w        = (cell_char == wall_char);
    assign wdata    = {w, slot0_reg[1]};
    assign slot1    = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign col_plus1 = col_reg + COL_W'(1);

    // look two columns ahead, wrapping into the next row
    always_comb
    begin
        if (col_reg == last_col)
        begin
            rd_addr = (last_col != '0) ? COL_W'(1) : '0;
        end
        else if (col_plus1 == last_col)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = col_plus1 + COL_W'(1);
        end
    end

    fwcc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign r_ge1  = (row_reg != '0);
    assign r_ge2  = r_ge1 && (row_reg != ROW_W'(1));
    assign c_ge1  = (col_reg != '0);
    assign c_ge2  = c_ge1 && (col_reg != COL_W'(1));
    assign c_last = (col_reg == last_col);
    assign r_last = (row_reg == last_row);

    assign pass_a = w && (!r_ge2 || slot0_reg[0]) && (!c_ge1 || ob_prev_reg)
                    && (c_last || slot1[1]);
    assign pass_b = w && (!r_ge1 || ob_prev_reg) && (!c_ge2 || cur2_reg);
    assign pass_c = (!r_ge1 || slot0_reg[1]) && (!c_ge1 || cur1_reg);

    always_comb
    begin
        push_data.row    = OUT_ROW_W'(32'(row_reg));
        push_data.col    = OUT_COL_W'(32'(col_reg));
        push_data.has_a  = r_ge1;
        push_data.has_b  = r_last && c_ge1;
        push_data.has_c  = r_last && c_last;
        push_data.pass_a = pass_a;
        push_data.pass_b = pass_b;
        push_data.pass_c = pass_c;
    end

    assign push = accept && (push_data.has_a || push_data.has_b || push_data.has_c);

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        byp_valid_next = byp_valid_reg;
        slot0_next     = slot0_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (c_last)
            begin
                col_next = '0;
                row_next = r_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_plus1;
            end
        end
        if (accept)
        begin
            byp_valid_next = (rd_addr == col_reg);
            slot0_next     = (last_col == '0) ? wdata : slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        if (accept)
        begin
            byp_data_reg <= wdata;
            ob_prev_reg  <= slot0_reg[1];
            cur1_reg     <= w;
            cur2_reg     <= cur1_reg;
        end
    end

    `FWCC_ASSERT_NOW(a_col_in_row, 1'b1, col_reg <= last_col, "column count past row end")
    `FWCC_ASSERT_NOW(a_row_in_grid, 1'b1, row_reg <= last_row, "row count past grid end")
    `FWCC_ASSERT_NEXT(a_row_wrap, accept && c_last && !restart, col_reg == '0,
        "column count did not wrap at row end")

endmodule

`default_nettype wire

// ----- hdl/fwcc_fifo.sv -----
// ----------------------------------------------------------------------------
// fwcc_fifo
// short queue of result bundles between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_neighbour_wall_check_core_defines.svh"

module fwcc_fifo
    import fwcc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output bundle_t      head,
    output logic         full,
    output logic         empty
);

    bundle_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `FWCC_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
    `FWCC_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")
    `FWCC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH),
        "queue count out of range")

endmodule

`default_nettype wire

// ----- hdl/fwcc_back.sv -----
// ----------------------------------------------------------------------------
// fwcc_back
// splits result bundles into single result transactions behind an
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module fwcc_back
    import fwcc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fifo_empty,
    input  wire bundle_t          head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [OUT_ROW_W-1:0]  cell_row,
    output logic [OUT_COL_W-1:0]  cell_col,
    output logic                  all_walls,
    output logic                  run_last,
    output logic                  frame_done
);

    bundle_t              work_reg, work_next;
    logic [2:0]           mask_reg, mask_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_ROW_W-1:0] row_reg;
    logic [OUT_COL_W-1:0] col_reg;
    logic                 pass_reg, last_reg, done_reg;

    logic                 load_out;
    logic [2:0]           sel;
    logic [2:0]           remain;
    logic [OUT_ROW_W-1:0] row_sel;
    logic [OUT_COL_W-1:0] col_sel;
    logic                 pass_sel;

    assign load_out = (mask_reg != '0) && (!out_valid_reg || out_ready);

    // results leave in order: above, left, bottom-right
    always_comb
    begin
        priority if (mask_reg[0])
        begin
            sel      = 3'b001;
            row_sel  = work_reg.row - OUT_ROW_W'(1);
            col_sel  = work_reg.col;
            pass_sel = work_reg.pass_a;
        end
        else if (mask_reg[1])
        begin
            sel      = 3'b010;
            row_sel  = work_reg.row;
            col_sel  = work_reg.col - OUT_COL_W'(1);
            pass_sel = work_reg.pass_b;
        end
        else
        begin
            sel      = 3'b100;
            row_sel  = work_reg.row;
            col_sel  = work_reg.col;
            pass_sel = work_reg.pass_c;
        end
    end

    assign remain = mask_reg & ~sel;
    assign pop    = !fifo_empty && ((mask_reg == '0) || (load_out && remain == '0));

    always_comb
    begin
        work_next = work_reg;
        mask_next = mask_reg;
        if (pop)
        begin
            work_next = head;
            mask_next = {head.has_c, head.has_b, head.has_a};
        end
        else if (load_out)
        begin
            mask_next = remain;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (load_out)
        begin
            row_reg  <= row_sel;
            col_reg  <= col_sel;
            pass_reg <= pass_sel;
            last_reg <= (remain == '0);
            done_reg <= sel[2];
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_row   = row_reg;
    assign cell_col   = col_reg;
    assign all_walls  = pass_reg;
    assign run_last   = last_reg;
    assign frame_done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/four_neighbour_wall_check_core.sv -----
// ----------------------------------------------------------------------------
// four_neighbour_wall_check_core
// four neighbour wall test over a raster character grid
// ----------------------------------------------------------------------------
// input channel: one grid cell character per transaction, raster order.
// output channel: row, column and pass flag for every cell of the grid, sent
//   when the cell below arrives; last row cells follow their right neighbour
//   or the frame end. up to three results per input, run_last marks the last.
// one input transaction per cycle; the only limit is the output channel,
//   which moves one result per ready cycle through a four-entry bundle queue.
// an input's results pass through the queue, work and output registers.
// column history lives in a 2-bit wide ram of MAX_COLS entries, one write and
//   one look-ahead read per input.
// reset: grid 1x1, wall '#', position at top-left; ram contents are not
//   cleared; stale entries are read but unused before this frame writes them.
// any register write restarts the frame at the top-left cell.
// a stalled receiver holds the output register; the queue absorbs up to four
//   bundles and then in_ready drops until the back end pops one.
// ----------------------------------------------------------------------------
`default_nettype none

module four_neighbour_wall_check_core
    import fwcc_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CHAR_W-1:0]     cell_char,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [OUT_ROW_W-1:0]  cell_row,
    output logic      [OUT_COL_W-1:0]  cell_col,
    output logic                       all_walls,
    output logic                       run_last,
    output logic                       frame_done
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [CFG_W-1:0]  grid_rows_reg;
    logic [CFG_W-1:0]  grid_cols_reg;
    logic [CHAR_W-1:0] wall_char_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;
    logic              restart;
    logic [ROW_W-1:0]  last_row;
    logic [COL_W-1:0]  last_col;

    logic              fifo_full;
    logic              fifo_empty;
    logic              push;
    logic              pop;
    bundle_t           push_data;
    bundle_t           head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_ROWS: restart = wr_en;
            REG_GRID_COLS: restart = wr_en;
            REG_WALL_CHAR: restart = wr_en;
            default:       restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RESET;
            grid_cols_reg <= GRID_COLS_RESET;
            wall_char_reg <= WALL_CHAR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[CFG_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[CFG_W-1:0];
                REG_WALL_CHAR: wall_char_reg <= pwdata[CHAR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_ROWS: prdata = 32'(grid_rows_reg);
            REG_GRID_COLS: prdata = 32'(grid_cols_reg);
            REG_WALL_CHAR: prdata = 32'(wall_char_reg);
            default:       prdata = '0;
        endcase
    end

    // zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (grid_rows_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(grid_rows_reg) > MAX_ROWS)
        begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = ROW_W'(grid_rows_reg - CFG_W'(1));
        end

        if (grid_cols_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(grid_cols_reg) > MAX_COLS)
        begin
            last_col = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            last_col = COL_W'(grid_cols_reg - CFG_W'(1));
        end
    end

    fwcc_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .last_row  (last_row),
        .last_col  (last_col),
        .wall_char (wall_char_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_char (cell_char),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    fwcc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    fwcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .all_walls  (all_walls),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

endmodule

`default_nettype wire
